// ----- hdl/bbrm_pkg.sv -----
// ----------------------------------------------------------------------------
// bbrm_pkg
// Shared widths, operation codes and payload structs for the bip buffer
// region manager.
// ----------------------------------------------------------------------------
`default_nettype none

package bbrm_pkg;

	// Field widths of the request and result beats
	localparam int MODE_W   = 3;
	localparam int AMT_W    = 17;
	localparam int CAP_W    = 17;
	localparam int OFS_W    = 18;
	localparam int LEN_W    = 17;
	localparam int TOTAL_W  = 32;

	// Default offset width; offsets are kept with one extra bit for the mirror
	localparam int BBRM_OFFSET_BITS = 17;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

	// Operation codes; the two unused codes act as a no-op
	typedef enum logic [MODE_W-1:0] {
		MODE_RESERVE_ALL   = 3'd0,
		MODE_RESERVE_EXACT = 3'd1,
		MODE_COMMIT        = 3'd2,
		MODE_DECOMMIT      = 3'd3,
		MODE_READ_SUM      = 3'd4,
		MODE_RESET_REGIONS = 3'd5
	} mode_t;

	// One operation as held in the input stage
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [AMT_W-1:0]  amount;
		logic              clear_sum;
	} op_t;

	// One result beat
	typedef struct packed {
		logic               status;
		logic [OFS_W-1:0]   grant_offset;
		logic [LEN_W-1:0]   grant_length;
		logic               move_needed;
		logic [OFS_W-1:0]   move_from;
		logic [LEN_W-1:0]   committed_bytes;
		logic [TOTAL_W-1:0] commit_total;
		logic [OFS_W-1:0]   region_start;
	} res_t;

endpackage

`default_nettype wire

// ----- hdl/bbrm_if.sv -----
// ----------------------------------------------------------------------------
// bbrm_req_if / bbrm_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbrm_req_if;
	import bbrm_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [AMT_W-1:0]  amount;
	logic              clear_sum;

	modport source (output valid, output mode, output amount, output clear_sum,
		input ready);
	modport sink (input valid, input mode, input amount, input clear_sum,
		output ready);
endinterface

interface bbrm_rsp_if;
	import bbrm_pkg::*;

	logic               valid;
	logic               ready;
	logic               status;
	logic [OFS_W-1:0]   grant_offset;
	logic [LEN_W-1:0]   grant_length;
	logic               move_needed;
	logic [OFS_W-1:0]   move_from;
	logic [LEN_W-1:0]   committed_bytes;
	logic [TOTAL_W-1:0] commit_total;
	logic [OFS_W-1:0]   region_start;

	modport source (output valid, output status, output grant_offset,
		output grant_length, output move_needed, output move_from,
		output committed_bytes, output commit_total, output region_start,
		input ready);
	modport sink (input valid, input status, input grant_offset,
		input grant_length, input move_needed, input move_from,
		input committed_bytes, input commit_total, input region_start,
		output ready);
endinterface

`default_nettype wire

// ----- hdl/bbrm_core.sv -----
// ----------------------------------------------------------------------------
// bbrm_core
// Region state registers, capacity register and the single-pass operation
// logic that updates them and forms one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrm_core #(
	parameter int OFFSET_BITS = bbrm_pkg::BBRM_OFFSET_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [bbrm_pkg::CAP_W-1:0] cfg_wdata,
	input  wire logic                     adv,
	input  wire bbrm_pkg::op_t            op,
	output bbrm_pkg::res_t                res
);
	import bbrm_pkg::*;

	// Offset width spans the mirror; compares run at the wider of offset/amount
	localparam int OW = OFFSET_BITS + 1;
	localparam int CW = (OW > AMT_W) ? OW : AMT_W;

	logic [CAP_W-1:0]   capacity_q;
	logic [OW-1:0]      region_begin_q, region_end_q, hold_begin_q, hold_end_q;
	logic [TOTAL_W-1:0] sum_q;

	logic [OW-1:0]      region_begin_n, region_end_n, hold_begin_n, hold_end_n;
	logic [TOTAL_W-1:0] sum_n, total;

	logic [CW-1:0]      cap_x, cap_max, want_x;
	logic [OW-1:0]      eff_cap, used, hold_sz, freesp, mirror, tail, want_o;
	logic               refuse, tail_short;
	logic [AMT_W-1:0]   commit_n, decommit_n;

	// Shared reserve terms
	always_comb begin
		cap_x   = CW'(capacity_q);
		cap_max = CW'(1) << (OFFSET_BITS - 1);
		eff_cap = OW'((cap_x > cap_max) ? cap_max : cap_x);
		used    = region_end_q - region_begin_q;
		hold_sz = hold_end_q - hold_begin_q;
		freesp  = (used > eff_cap) ? '0 : eff_cap - used;
		want_x  = (op.mode == MODE_RESERVE_ALL) ? CW'(freesp) : CW'(op.amount);
		want_o  = OW'(want_x);
		refuse  = (hold_sz != '0) || (freesp == '0) || (want_x == '0) ||
			(want_x > CW'(freesp));
		mirror  = eff_cap << 1;
		tail    = (region_end_q > mirror) ? '0 : mirror - region_end_q;
		tail_short = CW'(tail) < want_x;
	end

	// Commit is clipped to an open reservation, decommit to the region size
	always_comb begin
		commit_n = op.amount;
		if ((hold_sz != '0) && (CW'(op.amount) > CW'(hold_sz))) begin
			commit_n = AMT_W'(hold_sz);
		end
		decommit_n = (CW'(op.amount) >= CW'(used)) ? AMT_W'(used) : op.amount;
	end

	// Operation decode: next state and result fields
	always_comb begin
		region_begin_n = region_begin_q;
		region_end_n   = region_end_q;
		hold_begin_n   = hold_begin_q;
		hold_end_n     = hold_end_q;
		sum_n          = sum_q;
		res            = '0;
		case (op.mode)
			MODE_RESERVE_ALL, MODE_RESERVE_EXACT: begin
				if (refuse) begin
					res.status = 1'b1;
				end else begin
					if (used == '0) begin
						region_begin_n = '0;
						region_end_n   = '0;
					end else if (tail_short) begin
						res.move_needed = 1'b1;
						res.move_from   = OFS_W'(region_begin_q);
						region_begin_n  = '0;
						region_end_n    = used;
					end
					hold_begin_n     = region_end_n;
					hold_end_n       = region_end_n + want_o;
					res.grant_offset = OFS_W'(region_end_n);
					res.grant_length = LEN_W'(want_x);
				end
			end
			MODE_COMMIT: begin
				if (hold_sz != '0) begin
					region_end_n = hold_begin_q + OW'(commit_n);
				end
				hold_begin_n = '0;
				hold_end_n   = '0;
				sum_n        = sum_q + TOTAL_W'(commit_n);
			end
			MODE_DECOMMIT: begin
				region_begin_n   = region_begin_q + OW'(decommit_n);
				res.grant_length = decommit_n;
			end
			MODE_RESET_REGIONS: begin
				region_begin_n = '0;
				region_end_n   = '0;
				hold_begin_n   = '0;
				hold_end_n     = '0;
			end
			default: begin
			end
		endcase
		total = sum_n;
		if ((op.mode == MODE_READ_SUM) && op.clear_sum) begin
			sum_n = '0;
		end
		res.committed_bytes = LEN_W'(region_end_n - region_begin_n);
		res.commit_total    = total;
		res.region_start    = OFS_W'(region_begin_n);
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Region state, updated as each operation leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_begin_q <= '0;
			region_end_q   <= '0;
			hold_begin_q   <= '0;
			hold_end_q     <= '0;
			sum_q          <= '0;
		end else if (adv) begin
			region_begin_q <= region_begin_n;
			region_end_q   <= region_end_n;
			hold_begin_q   <= hold_begin_n;
			hold_end_q     <= hold_end_n;
			sum_q          <= sum_n;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bip_buffer_region_manager.sv -----
// ----------------------------------------------------------------------------
// bip_buffer_region_manager
// Offset manager for a single-region bip buffer kept in a mirror store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per beat (mode, amount, clear_sum); rsp returns
//   exactly one result beat per operation, in order. Both are valid/ready.
//   cfg_we/cfg_wdata write the capacity register; write it only while no
//   operation is in flight.
// Path: an accepted operation waits in the input stage, then is loaded into
//   the result register and shown on rsp; a stall on rsp holds it in place.
// Throughput: one operation per cycle while rsp takes each result beat. The
//   region registers are read and written by one pass of compare/add logic
//   between the input stage and the result register, so back-to-back
//   operations see each other's updates.
// Reset: arst_n clears both stages, the regions, the reservation and the
//   commit sum, and sets the capacity to 4096.
// Stall: while rsp is held off, the result register keeps its beat and the
//   input stage can still take one more operation; after that req.ready drops
//   until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bip_buffer_region_manager #(
	parameter int OFFSET_BITS = bbrm_pkg::BBRM_OFFSET_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bbrm_pkg::CAP_W-1:0] cfg_wdata,
	bbrm_req_if.sink                        req,
	bbrm_rsp_if.source                      rsp
);
	import bbrm_pkg::*;

	op_t  op_s1;
	logic vld_s1;
	res_t res_s2;
	logic vld_s2;
	res_t res_c;
	logic adv;

	// Input stage moves on when the result register is free or being drained
	assign adv       = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || adv;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1.mode      <= req.mode;
			op_s1.amount    <= req.amount;
			op_s1.clear_sum <= req.clear_sum;
		end
	end

	bbrm_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.adv      (adv),
		.op       (op_s1),
		.res      (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign rsp.valid           = vld_s2;
	assign rsp.status          = res_s2.status;
	assign rsp.grant_offset    = res_s2.grant_offset;
	assign rsp.grant_length    = res_s2.grant_length;
	assign rsp.move_needed     = res_s2.move_needed;
	assign rsp.move_from       = res_s2.move_from;
	assign rsp.committed_bytes = res_s2.committed_bytes;
	assign rsp.commit_total    = res_s2.commit_total;
	assign rsp.region_start    = res_s2.region_start;

	// A refused reserve grants nothing and moves nothing
	a_refuse_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |->
		(rsp.grant_offset == '0) && (rsp.grant_length == '0) && !rsp.move_needed)
		else $error("refused reserve carries a grant or move");

	// A move always relocates the region to offset 0
	a_move_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.move_needed |-> !rsp.status && (rsp.region_start == '0))
		else $error("move reported without region at offset 0");

	// Both stages full and output stalled: no new request may be taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !rsp.ready |-> !req.ready)
		else $error("request accepted while pipeline is full");

	// A stalled operation must stay in the input stage, unchanged
	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(op_s1))
		else $error("input stage lost or changed a stalled operation");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bip buffer region manager. A table of directed
// operations walks the reservation, commit, decommit, sum and region-move
// paths from reset; then random phases run at a range of capacities. Each
// request beat is run through a local model of the region pointers; each
// result beat is compared field by field with the oldest prediction. Both
// channels idle and stall at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bbrm_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 750;
	localparam int MAX_WAIT       = 16;
	localparam int PHASES         = 10;

	// Codes with no operation behind them
	localparam logic [MODE_W-1:0] MODE_NOP_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_NOP_HI = 3'd7;

	localparam logic [OFS_W-1:0] CAP_CEIL   = OFS_W'(1) << (BBRM_OFFSET_BITS - 1);
	localparam logic [AMT_W-1:0] AMT_MAX    = '1;
	localparam logic [CAP_W-1:0] CAP_MAX    = '1;
	localparam logic [CAP_W-1:0] RANDOM_CAP = '0;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [AMT_W-1:0]  amount;
		logic              clear_sum;
		bit                pinned;
		res_t              want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	bbrm_req_if req ();
	bbrm_rsp_if rsp ();

	bip_buffer_region_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Region model state
	bit [CAP_W-1:0]   cap_model = CAP_RESET;
	bit [OFS_W-1:0]   reg_begin = '0;
	bit [OFS_W-1:0]   reg_end   = '0;
	bit [OFS_W-1:0]   hold_lo   = '0;
	bit [OFS_W-1:0]   hold_hi   = '0;
	bit [TOTAL_W-1:0] commit_sum = '0;

	res_t owed_results [$];
	bit   pin_on = 1'b0;
	res_t pin_res;
	bit   steady = 1'b0;
	int   mismatches = 0;
	int   idle_cycles = 0;
	int   n_ops = 0, n_granted = 0, n_refused = 0, n_moves = 0, n_settings = 1;

	dir_row_t dir_rows [23];
	logic [CAP_W-1:0] cap_plan [PHASES] = '{1, 131071, 7, 65536, 200, RANDOM_CAP,
		16, 65535, 3000, RANDOM_CAP};

	function automatic logic [OFS_W-1:0] usable_cap();
		return (cap_model > CAP_CEIL) ? CAP_CEIL : OFS_W'(cap_model);
	endfunction

	function automatic logic [OFS_W-1:0] used_bytes();
		return reg_end - reg_begin;
	endfunction

	function automatic logic [OFS_W-1:0] held_bytes();
		return hold_hi - hold_lo;
	endfunction

	function automatic logic [OFS_W-1:0] free_bytes();
		return (used_bytes() > usable_cap()) ? '0 : usable_cap() - used_bytes();
	endfunction

	// Apply one operation to the region model and return its result beat
	function automatic res_t region_step(op_t op);
		res_t             r;
		logic [OFS_W-1:0] room, want, mirror, tail, n;
		r = '0;
		n_ops++;
		case (op.mode)
		MODE_RESERVE_ALL, MODE_RESERVE_EXACT: begin
			room = free_bytes();
			want = (op.mode == MODE_RESERVE_ALL) ? room : OFS_W'(op.amount);
			if (held_bytes() != 0 || room == 0 || want == 0 || want > room) begin
				r.status = 1'b1;
				n_refused++;
			end else begin
				mirror = usable_cap() << 1;
				tail = (reg_end > mirror) ? '0 : mirror - reg_end;
				if (used_bytes() == 0) begin
					reg_begin = '0;
					reg_end = '0;
				end else if (tail < want) begin
					// committed data gets copied down to offset 0
					r.move_needed = 1'b1;
					r.move_from = reg_begin;
					reg_end = used_bytes();
					reg_begin = '0;
					n_moves++;
				end
				hold_lo = reg_end;
				hold_hi = reg_end + want;
				r.grant_offset = hold_lo;
				r.grant_length = LEN_W'(want);
				n_granted++;
			end
		end
		MODE_COMMIT: begin
			n = OFS_W'(op.amount);
			if (held_bytes() != 0) begin
				if (n > held_bytes())
					n = held_bytes();
				reg_end = hold_lo + n;
			end
			hold_lo = '0;
			hold_hi = '0;
			commit_sum += TOTAL_W'(n);
		end
		MODE_DECOMMIT: begin
			n = (OFS_W'(op.amount) >= used_bytes()) ? used_bytes() : OFS_W'(op.amount);
			reg_begin += n;
			r.grant_length = LEN_W'(n);
		end
		MODE_RESET_REGIONS: begin
			reg_begin = '0;
			reg_end = '0;
			hold_lo = '0;
			hold_hi = '0;
		end
		default: ;
		endcase
		r.commit_total = commit_sum;
		if (op.mode == MODE_READ_SUM && op.clear_sum)
			commit_sum = '0;
		r.committed_bytes = LEN_W'(used_bytes());
		r.region_start = reg_begin;
		return r;
	endfunction

	// Mostly reserve/commit/decommit traffic shaped by the current regions
	function automatic op_t random_op();
		op_t              op;
		int unsigned      pick;
		logic [OFS_W-1:0] room, held, used;
		room = free_bytes();
		held = held_bytes();
		used = used_bytes();
		op.mode = MODE_READ_SUM;
		op.amount = AMT_W'($urandom_range(0, AMT_MAX));
		op.clear_sum = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			op.mode = MODE_W'($urandom_range(0, 7));
		end else if (held != 0 && pick < 80) begin
			op.mode = MODE_COMMIT;
			op.amount = AMT_W'($urandom_range(0, held + held / 4));
		end else if (pick < 25) begin
			op.mode = MODE_RESERVE_ALL;
		end else if (pick < 30) begin
			// at or just past the free space
			op.mode = MODE_RESERVE_EXACT;
			op.amount = AMT_W'(room + $urandom_range(0, 3));
		end else if (pick < 50) begin
			op.mode = MODE_RESERVE_EXACT;
			op.amount = (room == 0) ? AMT_W'($urandom_range(0, 3))
				: AMT_W'($urandom_range(1, room));
		end else if (pick < 75) begin
			op.mode = MODE_DECOMMIT;
			op.amount = AMT_W'($urandom_range(0, used));
		end else if (pick < 86) begin
			op.mode = MODE_READ_SUM;
		end else if (pick < 90) begin
			op.mode = MODE_RESET_REGIONS;
		end else if (pick < 94) begin
			op.mode = pick[0] ? MODE_NOP_HI : MODE_NOP_LO;
		end else begin
			op.mode = MODE_COMMIT;
		end
		return op;
	endfunction

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
			mismatches++;
		end
	endtask

	task automatic compare_result(res_t want);
		check_field("status", 32'(want.status), 32'(rsp.status));
		check_field("grant_offset", 32'(want.grant_offset), 32'(rsp.grant_offset));
		check_field("grant_length", 32'(want.grant_length), 32'(rsp.grant_length));
		check_field("move_needed", 32'(want.move_needed), 32'(rsp.move_needed));
		check_field("move_from", 32'(want.move_from), 32'(rsp.move_from));
		check_field("committed_bytes", 32'(want.committed_bytes), 32'(rsp.committed_bytes));
		check_field("commit_total", want.commit_total, rsp.commit_total);
		check_field("region_start", 32'(want.region_start), 32'(rsp.region_start));
	endtask

	// Drive one request beat after a random gap (none in steady phases); returns at the falling edge after it is taken
	task automatic send_op(op_t op);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.mode = op.mode;
		req.amount = op.amount;
		req.clear_sum = op.clear_sum;
		req.valid = 1'b1;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid = 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		req.valid = 1'b0;
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		n_settings++;
	endtask

	// Result side: random stall before each beat (none in steady phases)
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall != 0) begin
				rsp.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready = 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Beat monitor, prediction and watchdog
	always @(posedge clk) begin
		res_t want;
		op_t  beat;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_we)
				cap_model = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				idle_cycles = 0;
				if (owed_results.size() == 0) begin
					$display("%0t: result beat with nothing outstanding", $time);
					mismatches++;
				end else begin
					compare_result(owed_results.pop_front());
				end
			end
			if (req.valid && req.ready) begin
				idle_cycles = 0;
				beat.mode = req.mode;
				beat.amount = req.amount;
				beat.clear_sum = req.clear_sum;
				want = region_step(beat);
				if (pin_on)
					want = pin_res;
				owed_results.push_back(want);
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int items;
		op_t op;
		// status, grant_offset, grant_length, move_needed, move_from,
		// committed_bytes, commit_total, region_start
		dir_rows = '{
			'{MODE_READ_SUM,      0,      0, 1, '{0, 0,    0,    0, 0,    0,    0,    0}},
			'{MODE_RESERVE_ALL,   0,      0, 1, '{0, 0,    4096, 0, 0,    0,    0,    0}},
			// reservation already open
			'{MODE_RESERVE_EXACT, 5,      0, 1, '{1, 0,    0,    0, 0,    0,    0,    0}},
			// commit clipped to the reservation
			'{MODE_COMMIT,        100000, 0, 1, '{0, 0,    0,    0, 0,    4096, 4096, 0}},
			// no free space
			'{MODE_RESERVE_ALL,   0,      0, 1, '{1, 0,    0,    0, 0,    4096, 4096, 0}},
			'{MODE_DECOMMIT,      1000,   0, 1, '{0, 0,    1000, 0, 0,    3096, 4096, 1000}},
			// zero size, then one past the free space
			'{MODE_RESERVE_EXACT, 0,      0, 1, '{1, 0,    0,    0, 0,    3096, 4096, 1000}},
			'{MODE_RESERVE_EXACT, 1001,   0, 1, '{1, 0,    0,    0, 0,    3096, 4096, 1000}},
			'{MODE_RESERVE_EXACT, 1000,   0, 1, '{0, 4096, 1000, 0, 0,    3096, 4096, 1000}},
			'{MODE_COMMIT,        999,    0, 1, '{0, 0,    0,    0, 0,    4095, 5095, 1000}},
			'{MODE_DECOMMIT,      4095,   0, 1, '{0, 0,    4095, 0, 0,    0,    5095, 5095}},
			// empty region snaps back to offset 0
			'{MODE_RESERVE_EXACT, 10,     0, 1, '{0, 0,    10,   0, 0,    0,    5095, 0}},
			'{MODE_COMMIT,        10,     0, 1, '{0, 0,    0,    0, 0,    10,   5105, 0}},
			// decommit clipped to the committed size
			'{MODE_DECOMMIT,      AMT_MAX, 0, 1, '{0, 0,   10,   0, 0,    0,    5105, 10}},
			// commit with no reservation still adds to the sum
			'{MODE_COMMIT,        7,      0, 1, '{0, 0,    0,    0, 0,    0,    5112, 10}},
			'{MODE_READ_SUM,      0,      1, 1, '{0, 0,    0,    0, 0,    0,    5112, 10}},
			'{MODE_NOP_LO,        AMT_MAX, 1, 1, '{0, 0,   0,    0, 0,    0,    0,    10}},
			'{MODE_RESET_REGIONS, 0,      0, 1, '{0, 0,    0,    0, 0,    0,    0,    0}},
			// walk the region toward the end of the mirror; the move is forced after the table
			'{MODE_RESERVE_ALL,   0,      0, 0, '0},
			'{MODE_COMMIT,        4096,   0, 0, '0},
			'{MODE_DECOMMIT,      4000,   0, 0, '0},
			'{MODE_RESERVE_ALL,   0,      0, 1, '{0, 4096, 4000, 0, 0,    96,   4096, 4000}},
			'{MODE_NOP_HI,        0,      0, 0, '0}
		};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.mode = '0;
		req.amount = '0;
		req.clear_sum = 1'b0;
		rsp.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk at the reset capacity
		foreach (dir_rows[i]) begin
			pin_on = dir_rows[i].pinned;
			pin_res = dir_rows[i].want;
			op.mode = dir_rows[i].mode;
			op.amount = dir_rows[i].amount;
			op.clear_sum = dir_rows[i].clear_sum;
			send_op(op);
		end
		pin_on = 1'b0;
		// finish the move case: commit to near the top, trim, then reserve past the tail
		op.clear_sum = 1'b0;
		op.mode = MODE_COMMIT;
		op.amount = 4000;
		send_op(op);
		op.mode = MODE_DECOMMIT;
		op.amount = 4090;
		send_op(op);
		op.mode = MODE_RESERVE_EXACT;
		op.amount = 200;
		send_op(op);
		drain();

		// Random phases, each at its own capacity; regions carry over
		items = RANDOM_ITEMS / PHASES;
		foreach (cap_plan[p]) begin
			steady = (p % 3 == 2);
			write_capacity((cap_plan[p] == RANDOM_CAP) ? CAP_W'($urandom_range(1, CAP_MAX))
				: cap_plan[p]);
			for (int k = 0; k < items; k++) begin
				send_op(random_op());
				// hold the sender until every result is back
				if (p == 1 && k == items / 2)
					drain();
			end
			drain();
		end
		steady = 1'b0;

		// Catch any results that never arrived
		repeat (12) @(posedge clk);
		if (owed_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, owed_results.size());
			mismatches++;
		end
		$display("Ran %0d operations across %0d capacity settings, 1 to beyond the ceiling.",
			n_ops, n_settings);
		$display("Reserves granted %0d, refused %0d; region moves to offset 0: %0d.",
			n_granted, n_refused, n_moves);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/bbrm_pkg.sv
hdl/bbrm_if.sv
hdl/bbrm_core.sv
hdl/bip_buffer_region_manager.sv
bench/tb.sv
